@@ design/sap_pkg.sv @@
// shared types, constants and weight tables for the sexagesimal angle parser
package sap_pkg;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_UNITS  = 3'd1,
    PH_SEP1   = 3'd2,
    PH_MINS   = 3'd3,
    PH_SEP2   = 3'd4,
    PH_SECS   = 3'd5,
    PH_ENDING = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  localparam int unsigned CharW   = 8;
  localparam int unsigned WholeW  = 17;
  localparam int unsigned FracW   = 32;
  localparam int unsigned ValueW  = 50;
  localparam int unsigned MagW    = 49;
  localparam int unsigned CountW  = 9;
  localparam int unsigned WexpW   = 4;

  localparam logic CFG_DECIMAL_MARK = 1'b0;
  localparam logic CFG_FIELD_SEP    = 1'b1;

  localparam logic [CharW-1:0] CH_NUL   = 8'd0;
  localparam logic [CharW-1:0] CH_TAB   = 8'd9;
  localparam logic [CharW-1:0] CH_SPACE = 8'd32;
  localparam logic [CharW-1:0] CH_MINUS = 8'd45;
  localparam logic [CharW-1:0] CH_ZERO  = 8'd48;
  localparam logic [CharW-1:0] CH_NINE  = 8'd57;

  localparam logic [CharW-1:0] DECIMAL_MARK_RST = 8'd46;
  localparam logic [CharW-1:0] FIELD_SEP_RST    = 8'd44;

  localparam logic [WholeW-1:0] WHOLE_MAX  = 17'd99999;
  localparam logic [WholeW-1:0] SIXTY      = 17'd60;
  localparam logic [FracW-1:0]  FRAC_MAX   = 32'hFFFF_FFFF;
  localparam logic [WexpW-1:0]  WEXP_LAST  = 4'd10;

  localparam logic [31:0] SCALE_UNITS = 32'd3600000000;
  localparam logic [31:0] SCALE_MINS  = 32'd60000000;
  localparam logic [31:0] SCALE_SECS  = 32'd1000000;

  localparam logic [31:0] UNIT_WEIGHT [11] = '{
    32'd3600000000, 32'd360000000, 32'd36000000, 32'd3600000, 32'd360000,
    32'd36000, 32'd3600, 32'd360, 32'd36, 32'd3, 32'd0
  };
  localparam logic [31:0] MIN_WEIGHT [11] = '{
    32'd60000000, 32'd6000000, 32'd600000, 32'd60000, 32'd6000,
    32'd600, 32'd60, 32'd6, 32'd0, 32'd0, 32'd0
  };
  localparam logic [31:0] SEC_WEIGHT [11] = '{
    32'd1000000, 32'd100000, 32'd10000, 32'd1000, 32'd100,
    32'd10, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0
  };

  typedef struct packed {
    logic [WholeW-1:0] units;
    logic [WholeW-1:0] minutes;
    logic [WholeW-1:0] seconds;
    logic [FracW-1:0]  frac;
    logic              neg;
    status_e           status;
    logic [CountW-1:0] count;
  } snap_t;

  // fraction digit weight after k truncating divisions of the field scale
  function automatic logic [31:0] digit_weight(phase_e ph, logic [WexpW-1:0] k);
    logic [31:0] w;
    w = '0;
    if (k <= WEXP_LAST) begin
      case (ph)
        PH_MINS: w = MIN_WEIGHT[k];
        PH_SECS: w = SEC_WEIGHT[k];
        default: w = UNIT_WEIGHT[k];
      endcase
    end
    return w;
  endfunction

endpackage

@@ design/sap_ifs.sv @@
// request channel interfaces for characters in and parsed values out
interface sap_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       buffer_end;

  modport source (output valid, output char_code, output buffer_end, input ready);
  modport sink (input valid, input char_code, input buffer_end, output ready);
endinterface

interface sap_result_if;
  logic               valid;
  logic               ready;
  logic signed [49:0] value_micro;
  logic [1:0]         status;
  logic [8:0]         consumed;

  modport source (output valid, output value_micro, output status, output consumed,
                  input ready);
  modport sink (input valid, input value_micro, input status, input consumed,
                output ready);
endinterface

@@ design/sap_parser.sv @@
// per-character parse state and its next-state update
module sap_parser #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [sap_pkg::CharW-1:0]   char_i,
  input  logic                        last_i,
  input  logic [sap_pkg::CharW-1:0]   decimal_mark_i,
  input  logic [sap_pkg::CharW-1:0]   field_sep_i,
  output logic                        emit_o,
  output sap_pkg::snap_t              snap_o
);

  localparam int unsigned PosW = $clog2(MAX_LEN + 1);

  sap_pkg::phase_e                  phase_q, phase_d;
  logic                             neg_q, neg_d;
  logic                             point_q, point_d;
  logic                             digit_q, digit_d;
  logic [sap_pkg::WholeW-1:0]       units_q, units_d;
  logic [sap_pkg::WholeW-1:0]       mins_q, mins_d;
  logic [sap_pkg::WholeW-1:0]       secs_q, secs_d;
  logic [sap_pkg::FracW-1:0]        frac_q, frac_d;
  logic [sap_pkg::WexpW-1:0]        wexp_q, wexp_d;
  logic [PosW-1:0]                  pos_q, pos_d;

  logic                             is_digit;
  logic                             is_blank;
  logic [3:0]                       dval;
  logic [sap_pkg::WexpW-1:0]        wexp_inc;
  logic [31:0]                      weight;
  logic [36:0]                      frac_sum;
  logic [sap_pkg::WholeW-1:0]       field_cur;
  logic [19:0]                      field_acc;
  logic [sap_pkg::WholeW-1:0]       field_sat;
  logic                             done;
  logic [PosW-1:0]                  pos_inc;
  logic [PosW-1:0]                  count;

  assign is_digit  = (char_i >= sap_pkg::CH_ZERO) && (char_i <= sap_pkg::CH_NINE);
  assign is_blank  = (char_i == sap_pkg::CH_SPACE) || (char_i == sap_pkg::CH_TAB);
  assign dval      = char_i[3:0];
  assign wexp_inc  = (wexp_q >= sap_pkg::WEXP_LAST) ? wexp_q : wexp_q + 4'd1;
  assign weight    = sap_pkg::digit_weight(phase_q, wexp_inc);
  assign frac_sum  = 37'(frac_q) + 37'(36'(dval) * 36'(weight));
  assign pos_inc   = pos_q + PosW'(1);

  always_comb begin
    case (phase_q)
      sap_pkg::PH_MINS: field_cur = mins_q;
      sap_pkg::PH_SECS: field_cur = secs_q;
      default:          field_cur = units_q;
    endcase
  end

  assign field_acc = 20'(field_cur) * 20'd10 + 20'(dval);
  assign field_sat = (field_acc > 20'(sap_pkg::WHOLE_MAX)) ? sap_pkg::WHOLE_MAX
                                                          : field_acc[sap_pkg::WholeW-1:0];

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    point_d = point_q;
    digit_d = digit_q;
    units_d = units_q;
    mins_d  = mins_q;
    secs_d  = secs_q;
    frac_d  = frac_q;
    wexp_d  = wexp_q;
    pos_d   = pos_q;
    done    = 1'b0;
    emit_o  = 1'b0;
    count   = pos_q;

    if (char_i == sap_pkg::CH_NUL) begin
      emit_o = 1'b1;
    end else begin
      unique case (phase_q)
        sap_pkg::PH_START, sap_pkg::PH_SEP1, sap_pkg::PH_SEP2: begin
          if (phase_q == sap_pkg::PH_START && char_i == sap_pkg::CH_MINUS) begin
            neg_d = 1'b1;
          end
          if (is_digit) begin
            digit_d = 1'b1;
            case (phase_q)
              sap_pkg::PH_SEP1: begin
                phase_d = sap_pkg::PH_MINS;
                mins_d  = 17'(dval);
              end
              sap_pkg::PH_SEP2: begin
                phase_d = sap_pkg::PH_SECS;
                secs_d  = 17'(dval);
              end
              default: begin
                phase_d = sap_pkg::PH_UNITS;
                units_d = 17'(dval);
              end
            endcase
          end
        end
        sap_pkg::PH_UNITS, sap_pkg::PH_MINS, sap_pkg::PH_SECS: begin
          if (char_i == decimal_mark_i) begin
            point_d = 1'b1;
            wexp_d  = '0;
          end else if (is_digit) begin
            if (point_q) begin
              wexp_d = wexp_inc;
              frac_d = (frac_sum > 37'(sap_pkg::FRAC_MAX)) ? sap_pkg::FRAC_MAX
                                                          : frac_sum[sap_pkg::FracW-1:0];
            end else begin
              case (phase_q)
                sap_pkg::PH_MINS: mins_d  = field_sat;
                sap_pkg::PH_SECS: secs_d  = field_sat;
                default:          units_d = field_sat;
              endcase
            end
          end else if (point_q || phase_q == sap_pkg::PH_SECS) begin
            if (is_blank) begin
              done = 1'b1;
            end else if (char_i == field_sep_i) begin
              done  = 1'b1;
              count = pos_inc;
            end else begin
              phase_d = sap_pkg::PH_ENDING;
            end
          end else begin
            case (phase_q)
              sap_pkg::PH_UNITS: phase_d = sap_pkg::PH_SEP1;
              default:           phase_d = sap_pkg::PH_SEP2;
            endcase
          end
        end
        sap_pkg::PH_ENDING: begin
          if (is_blank) begin
            done = 1'b1;
          end
        end
        default: begin
          phase_d = sap_pkg::PH_ENDING;
        end
      endcase

      if (done) begin
        emit_o = 1'b1;
      end else begin
        pos_d = pos_inc;
        count = pos_inc;
        if (last_i || pos_inc >= PosW'(MAX_LEN)) begin
          emit_o = 1'b1;
        end
      end
    end
  end

  always_comb begin
    snap_o.neg   = neg_d;
    snap_o.count = sap_pkg::CountW'(count);
    if (digit_d) begin
      snap_o.units   = units_d;
      snap_o.minutes = mins_d;
      snap_o.seconds = secs_d;
      snap_o.frac    = frac_d;
      snap_o.status  = sap_pkg::ST_OK;
    end else begin
      snap_o.units   = '0;
      snap_o.minutes = '0;
      snap_o.seconds = '0;
      snap_o.frac    = '0;
      snap_o.status  = sap_pkg::ST_NONE;
    end
    if (mins_d >= sap_pkg::SIXTY || secs_d >= sap_pkg::SIXTY) begin
      snap_o.status = sap_pkg::ST_RANGE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sap_pkg::PH_START;
      neg_q   <= 1'b0;
      point_q <= 1'b0;
      digit_q <= 1'b0;
      units_q <= '0;
      mins_q  <= '0;
      secs_q  <= '0;
      frac_q  <= '0;
      wexp_q  <= '0;
      pos_q   <= '0;
    end else if (accept_i) begin
      if (emit_o) begin
        phase_q <= sap_pkg::PH_START;
        neg_q   <= 1'b0;
        point_q <= 1'b0;
        digit_q <= 1'b0;
        units_q <= '0;
        mins_q  <= '0;
        secs_q  <= '0;
        frac_q  <= '0;
        wexp_q  <= '0;
        pos_q   <= '0;
      end else begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        point_q <= point_d;
        digit_q <= digit_d;
        units_q <= units_d;
        mins_q  <= mins_d;
        secs_q  <= secs_d;
        frac_q  <= frac_d;
        wexp_q  <= wexp_d;
        pos_q   <= pos_d;
      end
    end
  end

endmodule

@@ design/sap_scale.sv @@
// pipelined conversion of parsed fields to a signed micro-second value
module sap_scale (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  emit_i,
  input  sap_pkg::snap_t        snap_i,
  output logic                  ready_o,
  sap_result_if.source          res_o
);

  logic           v1_q, v2_q, v3_q, v4_q, v5_q;
  logic           en1, en2, en3, en4, en5;

  sap_pkg::snap_t s1_q;

  logic [48:0]    pu_q, pu_d;
  logic [42:0]    pm_q, pm_d;
  logic [36:0]    ps_q, ps_d;
  logic [31:0]    fr2_q;
  logic           neg2_q, neg3_q, neg4_q;
  logic [1:0]     st2_q, st3_q, st4_q;
  logic [8:0]     cnt2_q, cnt3_q, cnt4_q;

  logic [48:0]    a_q, a_d;
  logic [37:0]    b_q, b_d;
  logic [48:0]    mag_q, mag_d;

  logic signed [49:0] val_q, val_d;
  logic [1:0]         st5_q;
  logic [8:0]         cnt5_q;

  assign en5     = !v5_q || res_o.ready;
  assign en4     = !v4_q || en5;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  assign pu_d  = 49'(s1_q.units) * 49'(sap_pkg::SCALE_UNITS);
  assign pm_d  = 43'(s1_q.minutes) * 43'(sap_pkg::SCALE_MINS);
  assign ps_d  = 37'(s1_q.seconds) * 37'(sap_pkg::SCALE_SECS);
  assign a_d   = pu_q + 49'(pm_q);
  assign b_d   = 38'(ps_q) + 38'(fr2_q);
  assign mag_d = a_q + 49'(b_q);
  assign val_d = neg4_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= emit_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q <= snap_i;
    end
    if (en2) begin
      pu_q   <= pu_d;
      pm_q   <= pm_d;
      ps_q   <= ps_d;
      fr2_q  <= s1_q.frac;
      neg2_q <= s1_q.neg;
      st2_q  <= s1_q.status;
      cnt2_q <= s1_q.count;
    end
    if (en3) begin
      a_q    <= a_d;
      b_q    <= b_d;
      neg3_q <= neg2_q;
      st3_q  <= st2_q;
      cnt3_q <= cnt2_q;
    end
    if (en4) begin
      mag_q  <= mag_d;
      neg4_q <= neg3_q;
      st4_q  <= st3_q;
      cnt4_q <= cnt3_q;
    end
    if (en5) begin
      val_q  <= val_d;
      st5_q  <= st4_q;
      cnt5_q <= cnt4_q;
    end
  end

  assign res_o.valid       = v5_q;
  assign res_o.value_micro = val_q;
  assign res_o.status      = st5_q;
  assign res_o.consumed    = cnt5_q;

endmodule

@@ design/sexagesimal_angle_parser.sv @@
// top level: character in, signed sexagesimal value out
// one character is taken per cycle while ready; the parse state updates as it is taken
// the value a character ends passes the snapshot, product, sum, magnitude and result registers
// the scaling pipeline holds one value per stage; unstalled, values flow at one per cycle
// reset clears the parse state and pipeline valids and restores both mark registers
// output backpressure stalls the pipeline and then the character input
module sexagesimal_angle_parser #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  sap_char_if.sink             char_i,
  sap_result_if.source         res_o
);

  logic [sap_pkg::CharW-1:0] decimal_mark_q;
  logic [sap_pkg::CharW-1:0] field_sep_q;
  logic                      ready;
  logic                      accept;
  logic                      emit;
  sap_pkg::snap_t            snap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decimal_mark_q <= sap_pkg::DECIMAL_MARK_RST;
      field_sep_q    <= sap_pkg::FIELD_SEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sap_pkg::CFG_DECIMAL_MARK: decimal_mark_q <= cfg_wdata_i;
        sap_pkg::CFG_FIELD_SEP:    field_sep_q    <= cfg_wdata_i;
      endcase
    end
  end

  assign char_i.ready = ready;
  assign accept       = char_i.valid && ready;

  sap_parser #(
    .MAX_LEN (MAX_LEN)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .char_i         (char_i.char_code),
    .last_i         (char_i.buffer_end),
    .decimal_mark_i (decimal_mark_q),
    .field_sep_i    (field_sep_q),
    .emit_o         (emit),
    .snap_o         (snap)
  );

  sap_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .emit_i  (accept && emit),
    .snap_i  (snap),
    .ready_o (ready),
    .res_o   (res_o)
  );

endmodule

@@ test/tb_top.sv @@
// testbench for the sexagesimal angle parser: stimulus, predictor and result checks
`timescale 1ns / 100ps

module tb_top;
  import sap_pkg::*;

  localparam int unsigned MaxLen = 256;
  localparam int unsigned TotalChars = 1950;
  localparam int unsigned NumSettings = 6;
  localparam logic [7:0] FieldFillers [9] = '{
    8'd58, 8'd32, 8'd100, 8'd104, 8'd109, 8'd39, 8'd34, 8'hB0, 8'd45
  };

  typedef struct {
    logic signed [ValueW-1:0] value;
    status_e                  status;
    logic [CountW-1:0]        consumed;
  } angle_t;

  typedef struct {
    logic [CharW-1:0] code;
    logic             last;
    bit               typed;
    angle_t           want;
  } stim_row_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_idx;
  logic [CharW-1:0] cfg_wdata;

  sap_char_if   char_if ();
  sap_result_if res_if ();

  sexagesimal_angle_parser #(
    .MAX_LEN(MaxLen)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .char_i     (char_if),
    .res_o      (res_if)
  );

  // predictor copy of the parse state and mark registers
  logic [CharW-1:0]  mark_q;
  logic [CharW-1:0]  sep_q;
  phase_e            ph_q;
  logic              neg_q;
  logic              point_q;
  logic              digit_q;
  logic [WholeW-1:0] units_q;
  logic [WholeW-1:0] mins_q;
  logic [WholeW-1:0] secs_q;
  logic [FracW-1:0]  frac_q;
  logic [31:0]       weight_q;
  logic [CountW-1:0] pos_q;

  angle_t      pending_angles [$];
  stim_row_t   stim_rows [$];
  int unsigned chars_sent;
  int unsigned angles_seen;
  int unsigned range_seen;
  int unsigned empty_seen;
  int unsigned error_count;
  int unsigned settings_used;
  bit          calm;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic bit is_digit(logic [CharW-1:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic bit is_blank(logic [CharW-1:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic void clear_parser();
    ph_q     = PH_START;
    neg_q    = 1'b0;
    point_q  = 1'b0;
    digit_q  = 1'b0;
    units_q  = '0;
    mins_q   = '0;
    secs_q   = '0;
    frac_q   = '0;
    weight_q = '0;
    pos_q    = '0;
  endfunction

  function automatic logic [WholeW-1:0] whole_of(phase_e ph);
    case (ph)
      PH_MINS: return mins_q;
      PH_SECS: return secs_q;
      default: return units_q;
    endcase
  endfunction

  function automatic void set_whole(phase_e ph, logic [WholeW-1:0] v);
    case (ph)
      PH_MINS: mins_q = v;
      PH_SECS: secs_q = v;
      default: units_q = v;
    endcase
  endfunction

  function automatic logic [31:0] field_scale(phase_e ph);
    case (ph)
      PH_MINS: return SCALE_MINS;
      PH_SECS: return SCALE_SECS;
      default: return SCALE_UNITS;
    endcase
  endfunction

  function automatic angle_t close_angle(logic [CountW-1:0] count);
    angle_t      a;
    logic [63:0] mag;
    mag = 64'(units_q) * 64'd3600000000 + 64'(mins_q) * 64'd60000000
        + 64'(secs_q) * 64'd1000000 + 64'(frac_q);
    a.status = ST_OK;
    if (!digit_q) begin
      mag = '0;
      a.status = ST_NONE;
    end
    if (mins_q >= SIXTY || secs_q >= SIXTY) a.status = ST_RANGE;
    if (neg_q) mag = -mag;
    a.value = mag[ValueW-1:0];
    a.consumed = count;
    clear_parser();
    return a;
  endfunction

  function automatic bit predict_angle(input logic [CharW-1:0] c, input logic last,
                                       output angle_t a);
    logic        done;
    logic        keep_blank;
    logic [3:0]  d;
    logic [63:0] wide;
    done = 1'b0;
    keep_blank = 1'b0;
    d = 4'(c - CH_ZERO);
    if (c == CH_NUL) begin
      a = close_angle(pos_q);
      return 1'b1;
    end
    case (ph_q)
      PH_START, PH_SEP1, PH_SEP2: begin
        if (ph_q == PH_START && c == CH_MINUS) neg_q = 1'b1;
        if (is_digit(c)) begin
          ph_q = phase_e'(ph_q + 3'd1);
          set_whole(ph_q, WholeW'(d));
          digit_q = 1'b1;
        end
      end
      PH_UNITS, PH_MINS, PH_SECS: begin
        if (c == mark_q) begin
          point_q = 1'b1;
          weight_q = field_scale(ph_q);
        end else if (is_digit(c)) begin
          if (point_q) begin
            weight_q = weight_q / 10;
            wide = 64'(frac_q) + 64'(d) * 64'(weight_q);
            frac_q = (wide > 64'(FRAC_MAX)) ? FRAC_MAX : wide[FracW-1:0];
          end else begin
            wide = 64'(whole_of(ph_q)) * 10 + 64'(d);
            set_whole(ph_q, (wide > 64'(WHOLE_MAX)) ? WHOLE_MAX : wide[WholeW-1:0]);
          end
        end else if (point_q || ph_q == PH_SECS) begin
          if (is_blank(c)) begin
            done = 1'b1;
            keep_blank = 1'b1;
          end else if (c == sep_q) begin
            done = 1'b1;
          end else begin
            ph_q = PH_ENDING;
          end
        end else begin
          ph_q = phase_e'(ph_q + 3'd1);
        end
      end
      PH_ENDING: begin
        if (is_blank(c)) begin
          done = 1'b1;
          keep_blank = 1'b1;
        end
      end
      default: ph_q = PH_ENDING;
    endcase
    if (done) begin
      a = close_angle(keep_blank ? pos_q : CountW'(pos_q + 1'b1));
      return 1'b1;
    end
    pos_q = pos_q + 1'b1;
    if (last || pos_q >= MaxLen) begin
      a = close_angle(pos_q);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_row(logic [CharW-1:0] code, logic last, bit typed,
                                  logic signed [ValueW-1:0] value, status_e status,
                                  logic [CountW-1:0] consumed);
    stim_row_t r;
    r.code = code;
    r.last = last;
    r.typed = typed;
    r.want.value = value;
    r.want.status = status;
    r.want.consumed = consumed;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_row(s[i], 1'b0, 1'b0, '0, ST_OK, '0);
  endfunction

  function automatic void add_digits(ref logic [CharW-1:0] chars [$], input int unsigned n);
    repeat (n) chars.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
  endfunction

  task automatic send_char(input logic [CharW-1:0] c, input logic last);
    int unsigned gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      char_if.valid <= 1'b0;
    end
    @(negedge clk);
    char_if.valid <= 1'b1;
    char_if.char_code <= c;
    char_if.buffer_end <= last;
    do @(posedge clk); while (char_if.ready !== 1'b1);
    chars_sent++;
  endtask

  task automatic feed(input logic [CharW-1:0] c, input logic last);
    angle_t a;
    send_char(c, last);
    if (predict_angle(c, last, a)) pending_angles.push_back(a);
  endtask

  // a NUL closes any open value, then let the pipeline empty
  task automatic drain_parser();
    int unsigned waited;
    feed(CH_NUL, 1'b0);
    @(negedge clk);
    char_if.valid <= 1'b0;
    waited = 0;
    while (pending_angles.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CharW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DECIMAL_MARK) mark_q = data;
    else sep_q = data;
  endtask

  task automatic build_angle(ref logic [CharW-1:0] chars [$], output bit flag_last);
    int unsigned r;
    int unsigned fields;
    int unsigned term;
    int unsigned v;
    int unsigned f;
    bit          with_frac;
    chars.delete();
    flag_last = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      repeat ($urandom_range(1, 10)) chars.push_back(8'($urandom_range(0, 255)));
      flag_last = ($urandom_range(0, 3) == 0);
      return;
    end
    if (r < 24) begin
      // repeated decimal marks drive the fraction into saturation
      add_digits(chars, $urandom_range(1, 3));
      repeat ($urandom_range(2, 6)) begin
        chars.push_back(mark_q);
        add_digits(chars, 10);
      end
      chars.push_back(CH_NUL);
      return;
    end
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) chars.push_back(CH_SPACE);
    if ($urandom_range(0, 2) == 0) chars.push_back(CH_MINUS);
    fields = $urandom_range(1, 3);
    add_digits(chars, ($urandom_range(0, 9) == 0) ? 6 : $urandom_range(1, 3));
    for (f = 1; f < fields; f++) begin
      repeat ($urandom_range(1, 2)) chars.push_back(FieldFillers[$urandom_range(0, 8)]);
      v = $urandom_range(0, 69);
      if ($urandom_range(0, 7) == 0) begin
        add_digits(chars, 3);
      end else begin
        chars.push_back(8'(CH_ZERO + v / 10));
        chars.push_back(8'(CH_ZERO + v % 10));
      end
    end
    with_frac = $urandom_range(0, 1);
    if (with_frac) begin
      chars.push_back(mark_q);
      add_digits(chars, $urandom_range(1, 12));
      if ($urandom_range(0, 9) == 0) begin
        chars.push_back(mark_q);
        add_digits(chars, $urandom_range(1, 4));
      end
    end
    term = (with_frac || fields == 3) ? $urandom_range(0, 6) : $urandom_range(0, 2);
    case (term)
      0: chars.push_back(CH_NUL);
      1: flag_last = 1'b1;
      2: chars.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
      3: chars.push_back(sep_q);
      4: begin
        chars.push_back(8'($urandom_range(97, 122)));
        chars.push_back(CH_SPACE);
      end
      5: chars.push_back(8'($urandom_range(128, 255)));
      default: ;
    endcase
  endtask

  initial begin : result_stalls
    int unsigned hold;
    res_if.ready = 1'b0;
    hold = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold == 0 && !calm && $urandom_range(0, 3) == 0) hold = pick_gap();
      if (hold > 0) begin
        res_if.ready <= 1'b0;
        hold--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    angle_t want;
    if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      angles_seen++;
      if (pending_angles.size() == 0) begin
        $error("value_micro %0d arrived with no request pending", res_if.value_micro);
        error_count++;
      end else begin
        want = pending_angles.pop_front();
        if (res_if.value_micro !== want.value) begin
          $error("value_micro: expected %0d, got %0d", want.value, res_if.value_micro);
          error_count++;
        end
        if (res_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_if.status);
          error_count++;
        end
        if (res_if.consumed !== want.consumed) begin
          $error("consumed: expected %0d, got %0d", want.consumed, res_if.consumed);
          error_count++;
        end
        if (want.status == ST_RANGE) range_seen++;
        if (want.status == ST_NONE) empty_seen++;
      end
    end
  end

  initial begin
    #30ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    angle_t           a;
    stim_row_t        row;
    logic [CharW-1:0] chars [$];
    logic [CharW-1:0] marks [NumSettings];
    logic [CharW-1:0] seps [NumSettings];
    bit               flag_last;
    bit               has;
    bit               long_done;
    int unsigned      phase_end;
    int unsigned      vals;
    int unsigned      p;

    cfg_we = 1'b0;
    cfg_idx = CFG_DECIMAL_MARK;
    cfg_wdata = '0;
    char_if.valid = 1'b0;
    char_if.char_code = CH_NUL;
    char_if.buffer_end = 1'b0;
    rst_n = 1'b0;
    calm = 1'b0;
    chars_sent = 0;
    angles_seen = 0;
    range_seen = 0;
    empty_seen = 0;
    error_count = 0;
    settings_used = 0;
    long_done = 1'b0;
    vals = 0;
    mark_q = DECIMAL_MARK_RST;
    sep_q = FIELD_SEP_RST;
    clear_parser();

    marks = '{DECIMAL_MARK_RST, 8'hFF, 8'd53, 8'd44, 8'h00, 8'h00};
    seps  = '{FIELD_SEP_RST, 8'h00, 8'd32, 8'd46, 8'hFF, 8'h00};
    marks[NumSettings-1] = 8'($urandom_range(0, 255));
    seps[NumSettings-1] = 8'($urandom_range(0, 255));

    // nothing parsed yet
    add_row(CH_NUL, 1'b0, 1'b1, '0, ST_NONE, 9'd0);
    // whole units saturate, then a fraction digit
    add_text("123456.9");
    add_row(CH_NUL, 1'b0, 1'b0, '0, ST_OK, '0);
    // negative, minutes of sixty, ended by a tab that is not consumed
    add_text("-7:60:1");
    add_row(CH_TAB, 1'b0, 1'b1, -50'sd28801000000, ST_RANGE, 9'd7);
    // top code alone at the buffer end
    add_row(8'hFF, 1'b1, 1'b1, '0, ST_NONE, 9'd1);
    // fraction ended by the field separator
    add_text("5.3,");

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      send_char(row.code, row.last);
      has = predict_angle(row.code, row.last, a);
      if (row.typed) pending_angles.push_back(row.want);
      else if (has) pending_angles.push_back(a);
    end
    drain_parser();

    for (p = 0; p < NumSettings; p++) begin
      if (p != 0) begin
        write_reg(CFG_DECIMAL_MARK, marks[p]);
        write_reg(CFG_FIELD_SEP, seps[p]);
      end
      settings_used++;
      phase_end = chars_sent + TotalChars / NumSettings;
      while (chars_sent < phase_end) begin
        if (vals % 30 == 0) calm = ($urandom_range(0, 4) == 0);
        vals++;
        if (!long_done || $urandom_range(0, 249) == 0) begin
          // value whose length falls just short of, at or past the length limit
          long_done = 1'b1;
          feed(CH_ZERO + 8'd1, 1'b0);
          feed(CH_ZERO + 8'd2, 1'b0);
          repeat ($urandom_range(MaxLen - 4, MaxLen + 10)) feed(8'($urandom_range(97, 122)), 1'b0);
        end else begin
          build_angle(chars, flag_last);
          foreach (chars[i]) feed(chars[i], flag_last && i == chars.size() - 1);
        end
      end
      calm = 1'b0;
      drain_parser();
    end

    if (pending_angles.size() != 0) begin
      $error("%0d parsed values never arrived", pending_angles.size());
      error_count++;
    end

    $display("sent %0d characters over %0d mark and separator settings", chars_sent,
             settings_used);
    $display("checked %0d values: %0d out of range, %0d without a number", angles_seen,
             range_seen, empty_seen);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
